/* hdl/sklc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sklc_pkg
// Shared widths, types and register indexes for the scalar Kalman filter
// with lead compensation.
// ----------------------------------------------------------------------------
package sklc_pkg;

	localparam int VW        = 48;  // value width, signed Q16.32
	localparam int CW        = 48;  // covariance and noise width, unsigned Q8.40
	localparam int DTW       = 32;  // sample period width, Q8.24
	localparam int LRW       = 16;  // lead ratio width, Q0.16
	localparam int GW        = 33;  // gain width, Q1.32
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 48;
	localparam int MB        = 16;  // multiplier chunk width
	localparam int ACCW      = 96;  // accumulator width
	localparam int REMW      = 49;  // divider remainder and divisor width
	localparam int QUOW      = 48;  // divider quotient width
	localparam int DBITS     = 24;  // dividend bits shifted into the remainder

	typedef logic signed [VW-1:0] value_t;
	typedef logic [CW-1:0] cov_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD_RATIO        = 2'd3;

	typedef struct packed {
		logic div_load;
		logic div_step;
		logic mul_load;
		logic mul_step;
	} arith_ctl_t;

endpackage
`default_nettype wire

/* hdl/sklc_meas_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sklc_meas_if
// Measurement channel: valid/ready with one signed Q16.32 sample.
// ----------------------------------------------------------------------------
interface sklc_meas_if;
	import sklc_pkg::*;

	logic   valid;
	logic   ready;
	value_t measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface
`default_nettype wire

/* hdl/sklc_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sklc_result_if
// Result channel: valid/ready with compensated and filtered values.
// ----------------------------------------------------------------------------
interface sklc_result_if;
	import sklc_pkg::*;

	logic   valid;
	logic   ready;
	value_t compensated_value;
	value_t filtered_value;

	modport source (output valid, output compensated_value, output filtered_value,
		input ready);
	modport sink (input valid, input compensated_value, input filtered_value,
		output ready);
endinterface
`default_nettype wire

/* hdl/sklc_arith.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sklc_arith
// Shared arithmetic: restoring divider (one quotient bit per step) and a
// serial 48x16 multiply-accumulate, MSB chunk first, product registered.
// ----------------------------------------------------------------------------
module sklc_arith (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sklc_pkg::arith_ctl_t         ctl,
	input  logic [sklc_pkg::REMW-1:0]    div_init,
	input  logic [sklc_pkg::REMW-1:0]    div_divisor,
	input  logic [sklc_pkg::DBITS-1:0]   div_bits,
	input  logic [sklc_pkg::VW-1:0]      mul_a,
	input  logic [sklc_pkg::VW-1:0]      mul_b,
	output logic [sklc_pkg::QUOW-1:0]    quo_next,
	output logic [sklc_pkg::ACCW-1:0]    acc
);
	import sklc_pkg::*;

	logic [REMW-1:0]   rem_q;
	logic [REMW-1:0]   div_q;
	logic [DBITS-1:0]  bits_q;
	logic [QUOW-1:0]   quo_q;
	logic [REMW:0]     trial;
	logic [REMW:0]     diff;
	logic              ge;

	logic [VW-1:0]     a_q;
	logic [VW-1:0]     b_q;
	logic [VW+MB-1:0]  prod_q;
	logic              pv_q;
	logic [ACCW-1:0]   acc_q;

	assign trial    = {rem_q, bits_q[DBITS-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign quo_next = {quo_q[QUOW-2:0], ge};
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			rem_q  <= div_init;
			div_q  <= div_divisor;
			bits_q <= div_bits;
			quo_q  <= '0;
		end else if (ctl.div_step) begin
			rem_q  <= ge ? diff[REMW-1:0] : trial[REMW-1:0];
			bits_q <= {bits_q[DBITS-2:0], 1'b0};
			quo_q  <= quo_next;
		end

		if (ctl.mul_load) begin
			a_q   <= mul_a;
			b_q   <= mul_b;
			acc_q <= '0;
		end else if (ctl.mul_step) begin
			prod_q <= (VW+MB)'(a_q) * (VW+MB)'(b_q[VW-1 -: MB]);
			b_q    <= {b_q[VW-MB-1:0], MB'(0)};
			// the registered product of the previous chunk is accumulated
			if (pv_q) begin
				acc_q <= {acc_q[ACCW-MB-1:0], MB'(0)} + ACCW'(prod_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (ctl.mul_load) begin
			pv_q <= 1'b0;
		end else if (ctl.mul_step) begin
			pv_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

/* hdl/scalar_kalman_lead_compensation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_lead_compensation
// Scalar Kalman update with smoothed velocity and a lead term, run by a
// small sequencer over one shared divider and one serial multiplier.
// ----------------------------------------------------------------------------
// Sequence: a measurement runs the 32-step gain division, the 48-step
//   velocity division and five 48x16 multiply passes; the gain division is
//   skipped when measurement_noise is zero, the velocity division when the
//   estimate did not move or the velocity saturates. A new measurement is
//   accepted only once the previous result has been loaded for output.
// Reset: registers take their default values, estimate and velocity clear,
//   covariance is 1.0; the block is ready as soon as reset is released.
module scalar_kalman_lead_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sklc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sklc_pkg::CFG_DW-1:0]      cfg_data,
	sklc_meas_if.sink                        meas,
	sklc_result_if.source                    result
);
	import sklc_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'h0001,
		ST_GSET  = 13'h0002,
		ST_DIVG  = 13'h0004,
		ST_DSET  = 13'h0008,
		ST_MUL   = 13'h0010,
		ST_RND   = 13'h0020,
		ST_APPLY = 13'h0040,
		ST_PSET  = 13'h0080,
		ST_VSET  = 13'h0100,
		ST_DIVV  = 13'h0200,
		ST_ESET  = 13'h0400,
		ST_RSET  = 13'h0800,
		ST_LSET  = 13'h1000
	} state_t;

	typedef enum logic [1:0] {
		R_FILT = 2'd0,
		R_COV  = 2'd1,
		R_VEL  = 2'd2,
		R_LEAD = 2'd3
	} rop_t;

	localparam int RNDW = 57;
	localparam int SUMW = RNDW + 2;
	localparam int GAIN_STEPS = 32;
	localparam int VEL_STEPS  = QUOW;

	localparam cov_t            Q_RST     = 48'd1100;
	localparam cov_t            R_RST     = 48'h0100_0000_0000;
	localparam logic [DTW-1:0]  DT_RST    = 32'd1677722;
	localparam logic [LRW-1:0]  RATIO_RST = 16'd26214;
	localparam cov_t            COV_ONE   = 48'h0100_0000_0000;
	localparam logic [GW-1:0]   GAIN_ONE  = 33'h1_0000_0000;
	localparam logic [LRW-1:0]  W_NEW     = 16'd19661;
	localparam value_t          VMAX      = {1'b0, {(VW-1){1'b1}}};
	localparam value_t          VMIN      = {1'b1, {(VW-1){1'b0}}};

	// control and architectural state
	state_t           state_q;
	state_t           ret_q;
	rop_t             rop_q;
	logic [1:0]       nch_q;
	logic [5:0]       cnt_q;
	logic             ov_q;
	cov_t             q_q;
	cov_t             r_q;
	logic [DTW-1:0]   dt_q;
	logic [LRW-1:0]   ratio_q;
	value_t           x_q;
	cov_t             p_q;
	value_t           v_q;

	// per-item working registers
	value_t           z_q;
	cov_t             ppred_q;
	logic [GW-1:0]    k_q;
	value_t           filt_q;
	value_t           raw_q;
	value_t           vel_q;
	logic [RNDW-1:0]  rnd_q;
	logic             neg_q;
	value_t           comp_q;
	value_t           ofilt_q;

	arith_ctl_t       ctl;
	logic [REMW-1:0]  div_init;
	logic [REMW-1:0]  div_divisor;
	logic [DBITS-1:0] div_bits;
	logic [VW-1:0]    mul_a;
	logic [VW-1:0]    mul_b;
	logic [QUOW-1:0]  quo_next;
	logic [ACCW-1:0]  acc;

	logic [CW:0]      pp_sum;
	logic [CW:0]      den;
	value_t           ad_a;
	value_t           ad_b;
	logic [VW:0]      dab;
	logic [VW:0]      dba;
	logic             ad_neg;
	logic [VW-1:0]    ad_mag;
	logic             vsat;
	logic [QUOW-1:0]  lim;
	logic [QUOW-1:0]  qs;
	value_t           raw_div;
	logic [VW-1:0]    vel_mag;
	logic [40:0]      bias;
	logic [ACCW:0]    full;
	logic [RNDW-1:0]  rnd_nxt;
	value_t           base;
	logic [RNDW:0]    term;
	logic [SUMW-1:0]  sum;
	value_t           sat_sum;
	logic             lead_go;
	logic             res_load;
	logic             gdiv_last;
	logic             vdiv_last;

	sklc_arith u_arith (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.div_init    (div_init),
		.div_divisor (div_divisor),
		.div_bits    (div_bits),
		.mul_a       (mul_a),
		.mul_b       (mul_b),
		.quo_next    (quo_next),
		.acc         (acc)
	);

	assign meas.ready               = (state_q == ST_IDLE);
	assign result.valid             = ov_q;
	assign result.compensated_value = comp_q;
	assign result.filtered_value    = ofilt_q;

	assign pp_sum    = {1'b0, p_q} + {1'b0, q_q};
	assign den       = {1'b0, ppred_q} + {1'b0, r_q};
	assign lead_go   = !ov_q || result.ready;
	assign res_load  = (state_q == ST_APPLY) && (rop_q == R_LEAD) && lead_go;
	assign gdiv_last = (cnt_q == 6'(GAIN_STEPS - 1));
	assign vdiv_last = (cnt_q == 6'(VEL_STEPS - 1));

	// one signed difference pair, operands picked by the step
	always_comb begin
		case (state_q)
			ST_VSET: begin
				ad_a = filt_q;
				ad_b = x_q;
			end
			ST_ESET: begin
				ad_a = raw_q;
				ad_b = v_q;
			end
			default: begin
				ad_a = z_q;
				ad_b = x_q;
			end
		endcase
	end

	assign dab    = {ad_a[VW-1], ad_a} - {ad_b[VW-1], ad_b};
	assign dba    = {ad_b[VW-1], ad_b} - {ad_a[VW-1], ad_a};
	assign ad_neg = dab[VW];
	assign ad_mag = ad_neg ? dba[VW-1:0] : dab[VW-1:0];

	// quotient would reach 2^48: saturate, also covers a zero period
	assign vsat = {8'b0, ad_mag} >= {dt_q, 24'b0};

	assign lim     = neg_q ? QUOW'(VMIN) : QUOW'(VMAX);
	assign qs      = (quo_next > lim) ? lim : quo_next;
	assign raw_div = neg_q ? value_t'(~qs + 1'b1) : value_t'(qs);
	assign vel_mag = vel_q[VW-1] ? (~vel_q + 1'b1) : vel_q;

	// rounding: negative terms round half toward +inf via magnitude bias - 1;
	// the lead magnitude rounds half up before its sign is applied
	always_comb begin
		case (rop_q)
			R_VEL:   bias = 41'd1 << 15;
			R_LEAD:  bias = 41'd1 << 39;
			default: bias = 41'd1 << 31;
		endcase
		if (neg_q && rop_q != R_LEAD) begin
			bias = bias - 41'd1;
		end
		full = {1'b0, acc} + {{(ACCW-40){1'b0}}, bias};
		case (rop_q)
			R_VEL:   rnd_nxt = full[72:16];
			R_LEAD:  rnd_nxt = full[96:40];
			default: rnd_nxt = full[88:32];
		endcase
	end

	always_comb begin
		case (rop_q)
			R_VEL:   base = v_q;
			R_LEAD:  base = filt_q;
			default: base = x_q;
		endcase
		term = neg_q ? (~{1'b0, rnd_q} + 1'b1) : {1'b0, rnd_q};
		sum  = {{(SUMW-VW){base[VW-1]}}, base} + {term[RNDW], term};
		if ((&sum[SUMW-1:VW-1]) || !(|sum[SUMW-1:VW-1])) begin
			sat_sum = sum[VW-1:0];
		end else begin
			sat_sum = sum[SUMW-1] ? VMIN : VMAX;
		end
	end

	// arithmetic unit control and operand select
	always_comb begin
		ctl         = '0;
		div_init    = {1'b0, ppred_q};
		div_divisor = den[REMW-1:0];
		div_bits    = '0;
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			ST_GSET: begin
				ctl.div_load = (r_q != '0);
			end
			ST_DIVG, ST_DIVV: begin
				ctl.div_step = 1'b1;
			end
			ST_VSET: begin
				ctl.div_load = (ad_mag != '0) && !vsat;
				div_init     = {{(REMW-DBITS){1'b0}}, ad_mag[VW-1:DBITS]};
				div_divisor  = {{(REMW-DTW){1'b0}}, dt_q};
				div_bits     = ad_mag[DBITS-1:0];
			end
			ST_DSET: begin
				ctl.mul_load = 1'b1;
				mul_a        = ad_mag;
				mul_b        = {{(VW-GW){1'b0}}, k_q};
			end
			ST_PSET: begin
				ctl.mul_load = 1'b1;
				mul_a        = ppred_q;
				mul_b        = {{(VW-GW){1'b0}}, GAIN_ONE - k_q};
			end
			ST_ESET: begin
				ctl.mul_load = 1'b1;
				mul_a        = ad_mag;
				mul_b        = {W_NEW, {(VW-LRW){1'b0}}};
			end
			ST_RSET: begin
				ctl.mul_load = 1'b1;
				mul_a        = {{(VW-DTW){1'b0}}, dt_q};
				mul_b        = {ratio_q, {(VW-LRW){1'b0}}};
			end
			ST_LSET: begin
				ctl.mul_load = 1'b1;
				mul_a        = vel_mag;
				mul_b        = acc[VW-1:0];
			end
			ST_MUL: begin
				ctl.mul_step = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer, registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_RND;
			rop_q   <= R_FILT;
			nch_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			q_q     <= Q_RST;
			r_q     <= R_RST;
			dt_q    <= DT_RST;
			ratio_q <= RATIO_RST;
			x_q     <= '0;
			p_q     <= COV_ONE;
			v_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROCESS_NOISE:     q_q     <= cfg_data[CW-1:0];
					CFG_MEASUREMENT_NOISE: r_q     <= cfg_data[CW-1:0];
					CFG_SAMPLE_PERIOD:     dt_q    <= cfg_data[DTW-1:0];
					CFG_LEAD_RATIO:        ratio_q <= cfg_data[LRW-1:0];
					default: ;
				endcase
			end

			// a new result may replace the one leaving in the same cycle
			if (res_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && result.ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (meas.valid) begin
						state_q <= ST_GSET;
					end
				end
				ST_GSET: begin
					cnt_q   <= '0;
					state_q <= (r_q != '0) ? ST_DIVG : ST_DSET;
				end
				ST_DIVG: begin
					if (gdiv_last) begin
						state_q <= ST_DSET;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DSET: begin
					rop_q   <= R_FILT;
					nch_q   <= 2'd3;
					ret_q   <= ST_RND;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == {4'b0, nch_q}) begin
						state_q <= ret_q;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_RND: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					case (rop_q)
						R_FILT: state_q <= ST_PSET;
						R_COV: begin
							p_q     <= rnd_q[CW-1:0];
							state_q <= ST_VSET;
						end
						R_VEL: state_q <= ST_RSET;
						R_LEAD: begin
							if (lead_go) begin
								x_q     <= filt_q;
								v_q     <= vel_q;
								state_q <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_PSET: begin
					rop_q   <= R_COV;
					nch_q   <= 2'd3;
					ret_q   <= ST_RND;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_VSET: begin
					cnt_q   <= '0;
					state_q <= ((ad_mag != '0) && !vsat) ? ST_DIVV : ST_ESET;
				end
				ST_DIVV: begin
					if (vdiv_last) begin
						state_q <= ST_ESET;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ESET: begin
					rop_q   <= R_VEL;
					nch_q   <= 2'd1;
					ret_q   <= ST_RND;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_RSET: begin
					nch_q   <= 2'd1;
					ret_q   <= ST_LSET;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_LSET: begin
					rop_q   <= R_LEAD;
					nch_q   <= 2'd3;
					ret_q   <= ST_RND;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (meas.valid) begin
					z_q     <= meas.measurement;
					ppred_q <= pp_sum[CW] ? {CW{1'b1}} : pp_sum[CW-1:0];
				end
			end
			ST_GSET: begin
				// no noise term: full gain, or none when the prediction is zero too
				if (r_q == '0) begin
					k_q <= (ppred_q == '0) ? '0 : GAIN_ONE;
				end
			end
			ST_DIVG: begin
				if (gdiv_last) begin
					k_q <= {1'b0, quo_next[GAIN_STEPS-1:0]};
				end
			end
			ST_DSET, ST_ESET: begin
				neg_q <= ad_neg;
			end
			ST_PSET: begin
				neg_q <= 1'b0;
			end
			ST_VSET: begin
				neg_q <= ad_neg;
				if (ad_mag == '0) begin
					raw_q <= '0;
				end else if (vsat) begin
					raw_q <= ad_neg ? VMIN : VMAX;
				end
			end
			ST_DIVV: begin
				if (vdiv_last) begin
					raw_q <= raw_div;
				end
			end
			ST_LSET: begin
				neg_q <= vel_q[VW-1];
			end
			ST_RND: begin
				rnd_q <= rnd_nxt;
			end
			ST_APPLY: begin
				case (rop_q)
					R_FILT: filt_q <= sat_sum;
					R_VEL:  vel_q  <= sat_sum;
					R_LEAD: begin
						if (lead_go) begin
							comp_q  <= sat_sum;
							ofilt_q <= filt_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(meas.valid && meas.ready) |=> (state_q == ST_GSET))
		else $error("transfer did not start the gain step");

	a_cov_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && rop_q == R_COV) |=> (p_q <= ppred_q))
		else $error("updated covariance above predicted covariance");

	a_filt_between: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && rop_q == R_FILT) |=>
		((filt_q >= x_q && filt_q <= z_q) || (filt_q <= x_q && filt_q >= z_q)))
		else $error("estimate outside old estimate and measurement");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q == ST_APPLY && rop_q == R_LEAD))
		else $error("result valid without lead step");

endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scalar_kalman_lead_compensation. A directed table
// covers reset, value extremes, a zero sample period, the held estimate when
// the gain denominator is zero, and register extremes. Random phases follow,
// each with new register settings and noisy ramps as measurements. Results
// are checked against an in-bench fixed-point Kalman model or table values.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sklc_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RANDOM_SAMPLES = 700;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 150;

	localparam value_t VMAX = 48'sh7FFF_FFFF_FFFF;
	localparam value_t VMIN = 48'sh8000_0000_0000;

	localparam logic [CFG_DW-1:0] DEF_Q  = 48'd1100;
	localparam logic [CFG_DW-1:0] DEF_R  = 48'h0100_0000_0000;
	localparam logic [CFG_DW-1:0] DEF_DT = 48'd1677722;
	localparam logic [CFG_DW-1:0] DEF_LR = 48'd26214;

	localparam logic [GW-1:0] GAIN_ONE = 33'h1_0000_0000;
	localparam logic signed [127:0] SMOOTH_OLD = 128'sd45875;  // 0.7 in Q0.16
	localparam logic signed [127:0] SMOOTH_NEW = 128'sd19661;  // 0.3 in Q0.16

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{CFG_PROCESS_NOISE,
		CFG_MEASUREMENT_NOISE, CFG_SAMPLE_PERIOD, CFG_LEAD_RATIO};

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DW-1:0]      data;  // register value or measurement
		logic                   typed;
		value_t                 want_comp;
		value_t                 want_filt;
	} stim_row_t;

	typedef struct packed {
		value_t comp;
		value_t filt;
	} estimate_pair_t;

	localparam int N_ROWS = 30;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h0, 1'b1, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h7FFF_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h8000_0000_0000, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h0000_0000_0001, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'hFFFF_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		// zero sample period
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, 48'h0, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h7FFF_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h8000_0000_0000, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h0, 1'b0, 48'sh0, 48'sh0},
		// Q = R = 0: first sample is taken whole, then P = 0 and the estimate holds
		'{ROW_WRITE, CFG_PROCESS_NOISE, 48'h0, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_MEASUREMENT_NOISE, 48'h0, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_LEAD_RATIO, 48'h0, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, 48'h0000_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h7FFF_FFFF_FFFF, 1'b1, VMAX, VMAX},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h8000_0000_0000, 1'b1, VMAX, VMAX},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h0, 1'b1, VMAX, VMAX},
		// register maxima, dt = 1 so the raw velocity saturates
		'{ROW_WRITE, CFG_PROCESS_NOISE, 48'hFFFF_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_MEASUREMENT_NOISE, 48'hFFFF_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_LEAD_RATIO, 48'hA5A5_0000_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, 48'h5A5A_0000_0001, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h8000_0000_0000, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h7FFF_FFFF_FFFF, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h0001_0000_0000, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h8000_0000_0000, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_PROCESS_NOISE, DEF_Q, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_MEASUREMENT_NOISE, DEF_R, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_SAMPLE_PERIOD, DEF_DT, 1'b0, 48'sh0, 48'sh0},
		'{ROW_WRITE, CFG_LEAD_RATIO, DEF_LR, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'h0002_8000_0000, 1'b0, 48'sh0, 48'sh0},
		'{ROW_SAMPLE, CFG_PROCESS_NOISE, 48'hFFFE_0000_0000, 1'b0, 48'sh0, 48'sh0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	sklc_meas_if   meas_ch ();
	sklc_result_if result_ch ();

	scalar_kalman_lead_compensation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.meas      (meas_ch),
		.result    (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// model state and register copies
	value_t    kf_estimate = '0;
	cov_t      kf_cov      = 48'h0100_0000_0000;
	value_t    kf_velocity = '0;
	cov_t      reg_q       = DEF_Q;
	cov_t      reg_r       = DEF_R;
	logic [DTW-1:0] reg_dt = DEF_DT[DTW-1:0];
	logic [LRW-1:0] reg_lead = DEF_LR[LRW-1:0];

	estimate_pair_t awaited_estimates[$];
	int  error_count = 0;
	int  quiet_cycles = 0;
	bit  hold_request = 1'b0;
	bit  sender_steady = 1'b0;
	bit  receiver_steady = 1'b0;

	function automatic estimate_pair_t kalman_lead_step(input value_t z);
		logic [CW:0]   cov_sum;
		cov_t          ppred;
		logic [CW+1:0] den;
		logic [GW-1:0] k;
		logic [GW-1:0] k_rest;
		logic [127:0]  wide_u;
		logic signed [127:0] wide_s;
		logic signed [127:0] old_w;
		logic signed [127:0] new_w;
		logic signed [127:0] lead_s;
		logic signed [63:0]  fe;
		logic signed [63:0]  xe;
		logic signed [63:0]  ve;
		logic signed [63:0]  step;
		logic signed [63:0]  rawv;
		logic [63:0]   move;
		logic [63:0]   cap;
		logic [63:0]   quo;
		logic [63:0]   vmag;
		logic [63:0]   dt_lead;
		logic [63:0]   lead;
		value_t        filt;
		value_t        vel;
		estimate_pair_t o;

		// predicted covariance, saturating
		cov_sum = {1'b0, kf_cov} + {1'b0, reg_q};
		ppred = cov_sum[CW] ? '1 : cov_sum[CW-1:0];
		den = {2'b0, ppred} + {2'b0, reg_r};
		if (den == 0) begin
			k = '0;
		end else if ({2'b0, ppred} >= den) begin
			k = GAIN_ONE;
		end else begin
			wide_u = ({80'b0, ppred} << 32) / {78'b0, den};
			k = wide_u[GW-1:0];
		end
		k_rest = GAIN_ONE - k;

		old_w = kf_estimate;
		new_w = z;
		wide_s = old_w * $signed({95'b0, k_rest}) + new_w * $signed({95'b0, k})
			+ 128'sd2147483648;
		wide_s = wide_s >>> 32;
		filt = wide_s[VW-1:0];

		wide_u = {95'b0, k_rest} * {80'b0, ppred} + 128'd2147483648;
		kf_cov = wide_u[CW+31:32];

		// raw velocity: move * 2^24 / dt, truncated, clamped to the value range
		fe = filt;
		xe = kf_estimate;
		step = fe - xe;
		if (step < 0) begin
			move = -step;
			cap = 64'h0000_8000_0000_0000;
		end else begin
			move = step;
			cap = 64'h0000_7FFF_FFFF_FFFF;
		end
		if (move == 0) begin
			quo = '0;
		end else if (reg_dt == 0) begin
			quo = cap;
		end else begin
			wide_u = ({64'b0, move} << 24) / {96'b0, reg_dt};
			quo = (wide_u > {64'b0, cap}) ? cap : wide_u[63:0];
		end
		rawv = (step < 0) ? -$signed(quo) : $signed(quo);

		old_w = kf_velocity;
		new_w = rawv;
		wide_s = old_w * SMOOTH_OLD + new_w * SMOOTH_NEW + 128'sd32768;
		wide_s = wide_s >>> 16;
		vel = wide_s[VW-1:0];

		// lead = |v| * dt * ratio / 2^40, rounded half up, sign of v
		ve = vel;
		vmag = (ve < 0) ? -ve : ve;
		dt_lead = {32'b0, reg_dt} * {48'b0, reg_lead};
		wide_u = {64'b0, vmag} * {64'b0, dt_lead} + (128'd1 << 39);
		lead = wide_u[103:40];
		lead_s = {64'b0, lead};
		old_w = fe;
		wide_s = (ve < 0) ? old_w - lead_s : old_w + lead_s;
		new_w = VMAX;
		if (wide_s > new_w) begin
			wide_s = new_w;
		end
		new_w = VMIN;
		if (wide_s < new_w) begin
			wide_s = new_w;
		end

		o.comp = wide_s[VW-1:0];
		o.filt = filt;
		kf_estimate = filt;
		kf_velocity = vel;
		return o;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic int pick_gap(input int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 30);
		return $urandom_range(40, top);
	endfunction

	function automatic logic [CFG_DW-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DW-1:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: begin
				case (idx)
					CFG_PROCESS_NOISE:     v = DEF_Q;
					CFG_MEASUREMENT_NOISE: v = DEF_R;
					CFG_SAMPLE_PERIOD:     v = DEF_DT;
					default:               v = DEF_LR;
				endcase
			end
			default: v = rand48() >> $urandom_range(0, 47);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 100)
			$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DW-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_PROCESS_NOISE:     reg_q = data;
			CFG_MEASUREMENT_NOISE: reg_r = data;
			CFG_SAMPLE_PERIOD:     reg_dt = data[DTW-1:0];
			CFG_LEAD_RATIO:        reg_lead = data[LRW-1:0];
			default: ;
		endcase
	endtask

	// block is idle once every result is back
	task automatic settle();
		meas_ch.valid = 1'b0;
		while (awaited_estimates.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_sample(input value_t m, input logic typed,
		input value_t want_comp, input value_t want_filt);
		int gap;
		estimate_pair_t e;
		gap = sender_steady ? 0 : pick_gap(120);
		if (gap > 0) begin
			meas_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		meas_ch.valid = 1'b1;
		meas_ch.measurement = m;
		@(posedge clk);
		while (!meas_ch.ready)
			@(posedge clk);
		e = kalman_lead_step(m);
		if (typed) begin
			e.comp = want_comp;
			e.filt = want_filt;
		end
		awaited_estimates.push_back(e);
		@(negedge clk);
	endtask

	// result side
	initial begin
		int stall;
		estimate_pair_t want;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			stall = receiver_steady ? 0 : pick_gap(150);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			if (awaited_estimates.size() == 0) begin
				report_mismatch($sformatf("result transfer with no sample pending: %h %h",
					result_ch.compensated_value, result_ch.filtered_value));
			end else begin
				want = awaited_estimates.pop_front();
				if (result_ch.compensated_value !== want.comp)
					report_mismatch($sformatf("compensated_value got %h want %h",
						result_ch.compensated_value, want.comp));
				if (result_ch.filtered_value !== want.filt)
					report_mismatch($sformatf("filtered_value got %h want %h",
						result_ch.filtered_value, want.filt));
			end
		end
	end

	always @(posedge clk) begin
		if ((meas_ch.valid && meas_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int sent;
		int phase;
		int phase_len;
		int noise_shift;
		value_t track;
		value_t slope;
		value_t m;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PROCESS_NOISE;
		cfg_data = '0;
		meas_ch.valid = 1'b0;
		meas_ch.measurement = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_WRITE) begin
				settle();
				write_register(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				send_sample(DIRECTED[i].data, DIRECTED[i].typed,
					DIRECTED[i].want_comp, DIRECTED[i].want_filt);
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_SAMPLES) begin
			settle();
			foreach (REG_ORDER[r])
				write_register(REG_ORDER[r], pick_setting(REG_ORDER[r]));
			sender_steady = ($urandom_range(0, 3) == 0);
			receiver_steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(60, 120);
			track = $signed(rand48()) >>> $urandom_range(1, 20);
			slope = $signed(rand48()) >>> $urandom_range(10, 40);
			noise_shift = $urandom_range(12, 46);
			for (int n = 0; n < phase_len; n++) begin
				// long receiver hold-off while samples keep coming
				if (phase == 2 && n == 10)
					hold_request = 1'b1;
				case ($urandom_range(0, 19))
					0: m = rand48();
					1: begin
						case ($urandom_range(0, 4))
							0: m = VMAX;
							1: m = VMIN;
							2: m = '0;
							3: m = 48'sh1;
							default: m = -48'sh1;
						endcase
					end
					default: begin
						track = track + slope;
						m = track + ($signed(rand48()) >>> noise_shift);
					end
				endcase
				send_sample(m, 1'b0, '0, '0);
				sent++;
			end
			phase++;
		end

		meas_ch.valid = 1'b0;
		while (awaited_estimates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

/* scalar_kalman_lead_compensation.f */
hdl/sklc_pkg.sv
hdl/sklc_meas_if.sv
hdl/sklc_result_if.sv
hdl/sklc_arith.sv
hdl/scalar_kalman_lead_compensation.sv
test/tb.sv
